/* rtl/core/sorted_set_union_assert.svh */
// Assertion macros for the RTL of the sorted set union block.
`ifndef SORTED_SET_UNION_ASSERT_SVH
`define SORTED_SET_UNION_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ssu_pkg.sv */
`default_nettype none

package ssu_pkg;

	localparam int unsigned CAPACITY = 32;
	localparam int unsigned DATA_W   = 32;

	typedef logic signed [DATA_W-1:0] ssu_data_t;

	typedef struct packed {
		logic      insert;
		logic      shift_out;
		ssu_data_t value;
	} ssu_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/ssu_cell.sv */
`default_nettype none

module ssu_cell import ssu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ssu_cmd_t  cmd,
	input  wire logic      left_lt,
	input  wire ssu_data_t left_value,
	input  wire logic      left_valid,
	input  wire ssu_data_t right_value,
	input  wire logic      right_valid,
	output ssu_data_t      value,
	output logic           valid,
	output logic           lt,
	output logic           eq
);

	ssu_data_t value_q;
	logic      valid_q;

	assign lt    = valid_q && (value_q < cmd.value);
	assign eq    = valid_q && (value_q == cmd.value);
	assign value = value_q;
	assign valid = valid_q;

	// A cell whose value is below the new one keeps it. The first cell at or
	// above takes the new value, and every cell after it takes its left neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift_out) begin
			valid_q <= right_valid;
		end else if (cmd.insert && !lt) begin
			valid_q <= left_lt ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_out) begin
			value_q <= right_value;
		end else if (cmd.insert && !lt) begin
			value_q <= left_lt ? cmd.value : left_value;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sorted_set_union.sv */
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   value, from_second, last_item
// out      output     out_valid/out_ready result_value, last_result, overflow
//
// Each distinct element is inserted in order; in_ready is high while collecting.
// An element marked last_item starts the drain, which emits one result per
// transfer from the head of the cell row, N transfers for N distinct values.
// Input is stalled for the whole drain; the row and the overflow flag are empty
// after the last result. Reset clears all cells and the overflow flag.
`default_nettype none

`include "sorted_set_union_assert.svh"

module sorted_set_union import ssu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ssu_data_t value,
	input  wire logic      from_second,
	input  wire logic      last_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output ssu_data_t      result_value,
	output logic           last_result,
	output logic           overflow
);

	ssu_cmd_t              cmd;
	ssu_data_t             cell_value [CAPACITY];
	logic [CAPACITY-1:0]   cell_valid;
	logic [CAPACITY-1:0]   cell_lt;
	logic [CAPACITY-1:0]   cell_eq;
	logic                  draining_q;
	logic                  overflow_q;
	logic                  in_xfer;
	logic                  out_xfer;
	logic                  dup;
	logic                  full;

	assign in_ready  = !draining_q;
	assign out_valid = draining_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;
	assign dup       = |cell_eq;
	assign full      = cell_valid[CAPACITY-1];

	// List membership does not change the union.
	assign cmd.insert    = in_xfer && !dup && !full;
	assign cmd.shift_out = out_xfer;
	assign cmd.value     = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic      left_lt;
		ssu_data_t left_value;
		logic      left_valid;
		ssu_data_t right_value;
		logic      right_valid;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_value = '0;
			assign left_valid = 1'b0;
		end else begin : g_mid
			assign left_lt    = cell_lt[i-1];
			assign left_value = cell_value[i-1];
			assign left_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_value = cell_value[i+1];
			assign right_valid = cell_valid[i+1];
		end

		ssu_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_lt     (left_lt),
			.left_value  (left_value),
			.left_valid  (left_valid),
			.right_value (right_value),
			.right_valid (right_valid),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.lt          (cell_lt[i]),
			.eq          (cell_eq[i])
		);
	end

	assign result_value = cell_value[0];
	assign last_result  = !cell_valid[1];
	assign overflow     = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (in_xfer && last_item) begin
				draining_q <= 1'b1;
			end else if (out_xfer && last_result) begin
				draining_q <= 1'b0;
			end
			if (out_xfer && last_result) begin
				overflow_q <= 1'b0;
			end else if (in_xfer && !dup && full) begin
				overflow_q <= 1'b1;
			end
		end
	end

	for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_chk
		`SSU_ASSERT_NOW(a_valid_prefix, cell_valid[j+1], cell_valid[j], "valid cells not contiguous")
		`SSU_ASSERT_NOW(a_sorted, cell_valid[j+1], cell_value[j] < cell_value[j+1], "cells not ascending")
	end

	`SSU_ASSERT_NOW(a_head_valid, out_valid, cell_valid[0], "result offered from empty head cell")
	`SSU_ASSERT_NEXT(a_drain_start, in_xfer && last_item, out_valid && !in_ready, "drain did not start")
	`SSU_ASSERT_NEXT(a_drain_end, out_xfer && last_result, cell_valid == '0 && !overflow_q, "row not empty after drain")

endmodule

`default_nettype wire
